FILE: hdl/pdct_pkg.sv
// Package for the prescaled down-counter timer.
// Holds request codes, register offsets, mode bit positions, reset values and beat types.
// No dependencies.
package pdct_pkg;

   localparam int DEFAULT_BASE_PERIOD = 128;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   localparam logic [1:0] REQ_TICK       = 2'd0;
   localparam logic [1:0] REQ_WORD_READ  = 2'd1;
   localparam logic [1:0] REQ_WORD_WRITE = 2'd2;
   localparam logic [1:0] REQ_BYTE_WRITE = 2'd3;

   localparam logic [2:0] OFS_SETUP_LO = 3'd0;
   localparam logic [2:0] OFS_SETUP_HI = 3'd1;
   localparam logic [2:0] OFS_COUNTER  = 3'd2;
   localparam logic [2:0] OFS_MODE     = 3'd4;

   localparam int MODE_CONT   = 1;
   localparam int MODE_ENBEND = 2;
   localparam int MODE_ONCE   = 3;
   localparam int MODE_START  = 4;
   localparam int MODE_DIV16  = 5;
   localparam int MODE_DIV4   = 6;
   localparam int MODE_END    = 7;

   localparam logic [15:0] RELOAD_RESET = 16'o011000;
   localparam logic [15:0] COUNT_RESET  = 16'hFFFF;
   localparam logic [15:0] COUNT_WRAP   = 16'hFFFF;
   localparam logic [7:0]  MODE_RESET   = 8'h00;
   localparam logic [7:0]  MODE_READ_PAD = 8'hFF;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [2:0]  offset;
      logic [15:0] write_data;
   } item_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        end_flag;
   } result_type;

endpackage

FILE: hdl/pdct_core.sv
// Timer register file and single-pass execute logic for one bus or tick beat.
// Depends on pdct_pkg.
module pdct_core
   import pdct_pkg::*;
#(
   parameter int BASE_PERIOD = DEFAULT_BASE_PERIOD
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       exec_en,
   input  item_type   item,
   output result_type result
);

   localparam int CW = $clog2(BASE_PERIOD * 64);

   localparam logic [CW:0] PERIOD_1  = (CW + 1)'(BASE_PERIOD);
   localparam logic [CW:0] PERIOD_4  = (CW + 1)'(BASE_PERIOD * 4);
   localparam logic [CW:0] PERIOD_16 = (CW + 1)'(BASE_PERIOD * 16);
   localparam logic [CW:0] PERIOD_64 = (CW + 1)'(BASE_PERIOD * 64);

   logic [15:0]   reload_ff, reload_in;
   logic [15:0]   count_ff, count_in;
   logic [7:0]    mode_ff, mode_in;
   logic [CW-1:0] pres_ff, pres_in;

   logic [CW:0]   period;
   logic [CW:0]   pres_next;
   logic [7:0]    wr_byte;
   logic          mode_wr;
   logic [15:0]   rd;

   always_comb begin
      unique case ({mode_ff[MODE_DIV4], mode_ff[MODE_DIV16]})
         2'b00:   period = PERIOD_1;
         2'b01:   period = PERIOD_16;
         2'b10:   period = PERIOD_4;
         default: period = PERIOD_64;
      endcase
   end

   assign pres_next = {1'b0, pres_ff} + (CW + 1)'(1);
   assign wr_byte   = item.write_data[7:0];
   assign mode_wr   = (item.req_type == REQ_WORD_WRITE || item.req_type == REQ_BYTE_WRITE)
                      && item.offset == OFS_MODE;

   always_comb begin
      reload_in = reload_ff;
      count_in  = count_ff;
      mode_in   = mode_ff;
      pres_in   = pres_ff;
      rd        = 16'h0000;
      unique case (item.req_type)
         REQ_TICK: begin
            if (mode_ff[MODE_START]) begin
               if (pres_next < period) begin
                  pres_in = pres_next[CW-1:0];
               end else begin
                  pres_in = '0;
                  if (count_ff > 16'd1) begin
                     count_in = count_ff - 16'd1;
                  end else begin
                     if (mode_ff[MODE_ENBEND]) begin
                        mode_in[MODE_END] = 1'b1;
                     end
                     if (mode_ff[MODE_ONCE] && !mode_ff[MODE_CONT]) begin
                        count_in            = 16'h0000;
                        mode_in[MODE_START] = 1'b0;
                     end else if (mode_ff[MODE_CONT]) begin
                        count_in = COUNT_WRAP;
                     end else begin
                        count_in = reload_ff - 16'd1;
                     end
                  end
               end
            end
         end
         REQ_WORD_READ: begin
            if (item.offset == OFS_SETUP_LO) begin
               rd = reload_ff;
            end else if (item.offset == OFS_COUNTER) begin
               rd = count_ff;
            end else if (item.offset == OFS_MODE) begin
               rd = {MODE_READ_PAD, mode_ff};
            end
         end
         REQ_WORD_WRITE: begin
            if (item.offset == OFS_SETUP_LO) begin
               reload_in = item.write_data;
            end
         end
         default: begin
            if (item.offset == OFS_SETUP_LO) begin
               reload_in = {reload_ff[15:8], wr_byte};
            end else if (item.offset == OFS_SETUP_HI) begin
               reload_in = {wr_byte, reload_ff[7:0]};
            end
         end
      endcase
      if (mode_wr) begin
         if (!mode_ff[MODE_START] && wr_byte[MODE_START]) begin
            count_in = reload_ff;
            pres_in  = '0;
         end
         mode_in = wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff <= RELOAD_RESET;
         count_ff  <= COUNT_RESET;
         mode_ff   <= MODE_RESET;
         pres_ff   <= '0;
      end else if (exec_en) begin
         reload_ff <= reload_in;
         count_ff  <= count_in;
         mode_ff   <= mode_in;
         pres_ff   <= pres_in;
      end
   end

   assign result.read_data = rd;
   assign result.end_flag  = mode_in[MODE_END];

endmodule

FILE: hdl/prescaled_down_counter_timer.sv
// Prescaled down-counter timer: top level with input and result registers.
// Depends on pdct_pkg and pdct_core.
//
// Usage:
//   req channel carries one beat per clock tick or bus access. req_tuser holds
//   the request type (tick, word read, word write, byte write); req_tdata holds
//   the byte offset and the write data.
//   rsp channel returns exactly one beat per request: the read data (zero for
//   anything but a word read of setup, counter or mode) and the END flag as it
//   stands after the request took effect.
//   Path: a beat accepted goes into the input register, then executes into
//   the result register, which drives the response.
//   Throughput: one beat per cycle while rsp_tready is high; the execute step
//   reads and updates the timer registers in one pass, so ticks run back to back.
//   Stall: when rsp_tready is low the response holds, the input register
//   keeps at most one more beat, and req_tready drops once both are full.
//   Reset: setup = 4608, counter = 0xFFFF, mode = 0 (stopped), prescaler = 0,
//   both pipeline registers empty.
module prescaled_down_counter_timer
   import pdct_pkg::*;
#(
   parameter int BASE_PERIOD = DEFAULT_BASE_PERIOD
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [2:0] offset, [18:3] write_data, rest zero
   input  logic [1:0]            req_tuser,  // [1:0] req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // [15:0] read_data, [16] end_flag, rest zero
);

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type res_ff;
   result_type res_comb;
   logic       advance;
   logic       exec_en;
   logic       req_beat;

   assign advance    = !out_valid_ff || rsp_tready;
   assign exec_en    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   assign in_valid_in  = req_beat || (in_valid_ff && !advance);
   assign out_valid_in = exec_en || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         item_ff.req_type   <= req_tuser;
         item_ff.offset     <= req_tdata[2:0];
         item_ff.write_data <= req_tdata[18:3];
      end
      if (exec_en) begin
         res_ff <= res_comb;
      end
   end

   pdct_core #(
      .BASE_PERIOD(BASE_PERIOD)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .exec_en(exec_en),
      .item   (item_ff),
      .result (res_comb)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 17){1'b0}}, res_ff.end_flag, res_ff.read_data};

endmodule

FILE: dv/pdct_checker.sv
`timescale 1ns / 1ps
// Checker for the prescaled down-counter timer: watches both streams, predicts each reply.
// Depends on pdct_pkg; failures and the count of replies still due go to the testbench top.
module pdct_checker
   import pdct_pkg::*;
#(
   parameter int BASE_PERIOD = DEFAULT_BASE_PERIOD
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [2:0] offset, [18:3] write_data, rest zero
   input  logic [1:0]            req_tuser,  // [1:0] req_type
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,  // [15:0] read_data, [16] end_flag, rest zero
   output int                    failures,
   output int                    outstanding
);

   logic [15:0] setup_reg;
   logic [15:0] count_reg;
   logic [7:0]  mode_reg;
   int          prescale;
   result_type  due_replies[$];

   function automatic int period_of(input logic [7:0] m);
      int p;
      p = BASE_PERIOD;
      if (m[MODE_DIV16]) p = p * 16;
      if (m[MODE_DIV4]) p = p * 4;
      return p;
   endfunction

   task automatic write_mode(input logic [7:0] m);
      if (!mode_reg[MODE_START] && m[MODE_START]) begin
         count_reg = setup_reg;
         prescale  = 0;
      end
      mode_reg = m;
   endtask

   task automatic tick_timer();
      if (!mode_reg[MODE_START]) return;
      prescale = prescale + 1;
      if (prescale < period_of(mode_reg)) return;
      prescale = 0;
      if (count_reg > 16'd1) begin
         count_reg = count_reg - 16'd1;
         return;
      end
      if (mode_reg[MODE_ENBEND]) mode_reg[MODE_END] = 1'b1;
      if (mode_reg[MODE_ONCE] && !mode_reg[MODE_CONT]) begin
         count_reg = 16'd0;
         mode_reg[MODE_START] = 1'b0;
      end else if (mode_reg[MODE_CONT]) begin
         count_reg = COUNT_WRAP;
      end else begin
         count_reg = setup_reg - 16'd1;
      end
   endtask

   task automatic timer_access(input item_type it, output result_type res);
      res.read_data = 16'd0;
      case (it.req_type)
         REQ_TICK: begin
            tick_timer();
         end
         REQ_WORD_READ: begin
            if (it.offset == OFS_SETUP_LO) res.read_data = setup_reg;
            else if (it.offset == OFS_COUNTER) res.read_data = count_reg;
            else if (it.offset == OFS_MODE) res.read_data = {MODE_READ_PAD, mode_reg};
         end
         REQ_WORD_WRITE: begin
            if (it.offset == OFS_SETUP_LO) setup_reg = it.write_data;
            else if (it.offset == OFS_MODE) write_mode(it.write_data[7:0]);
         end
         default: begin
            if (it.offset == OFS_SETUP_LO) setup_reg[7:0] = it.write_data[7:0];
            else if (it.offset == OFS_SETUP_HI) setup_reg[15:8] = it.write_data[7:0];
            else if (it.offset == OFS_MODE) write_mode(it.write_data[7:0]);
         end
      endcase
      res.end_flag = mode_reg[MODE_END];
   endtask

   always @(posedge clock) begin
      item_type   it;
      result_type want;
      if (reset) begin
         setup_reg   = RELOAD_RESET;
         count_reg   = COUNT_RESET;
         mode_reg    = MODE_RESET;
         prescale    = 0;
         failures    = 0;
         due_replies.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_replies.size() == 0) begin
               $error("reply beat with no reply due: tdata %h", rsp_tdata);
               failures = failures + 1;
            end else begin
               want = due_replies.pop_front();
               if (rsp_tdata[15:0] !== want.read_data) begin
                  $error("read_data: expected %h, actual %h", want.read_data, rsp_tdata[15:0]);
                  failures = failures + 1;
               end
               if (rsp_tdata[16] !== want.end_flag) begin
                  $error("end_flag: expected %b, actual %b", want.end_flag, rsp_tdata[16]);
                  failures = failures + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            it.req_type   = req_tuser;
            it.offset     = req_tdata[2:0];
            it.write_data = req_tdata[18:3];
            timer_access(it, want);
            due_replies.push_back(want);
         end
      end
      outstanding = due_replies.size();
   end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the prescaled down-counter timer: clock, reset, bus and tick stimulus.
// Depends on pdct_pkg, pdct_checker and the prescaled_down_counter_timer RTL.
module tb;
   import pdct_pkg::*;

   localparam int PLANNED_BEATS = 1680;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 8;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = REQ_TICK;
   logic                  rsp_tready = 1'b0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int failures;
   int outstanding;
   int gap_pct    = 6;
   int stall_pct  = 63;
   int beats_sent = 0;
   int cycles     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   prescaled_down_counter_timer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   pdct_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_beat(input logic [1:0] kind, input logic [2:0] ofs,
                            input logic [15:0] data);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_DATA_W-19){1'b0}}, data, ofs};
      do @(posedge clock); while (!req_tready);
      beats_sent = beats_sent + 1;
      if (beats_sent == PLANNED_BEATS / 3) begin
         gap_pct   = 63;
         stall_pct = 6;
      end else if (beats_sent == 2 * PLANNED_BEATS / 3) begin
         gap_pct   = 0;
         stall_pct = 0;
      end
   endtask

   // hold the bus idle until every reply is back
   task automatic wait_replies();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic noise_burst();
      logic [1:0]  kind;
      logic [2:0]  ofs;
      logic [15:0] data;
      int          n;
      n = $urandom_range(1, 6);
      repeat (n) begin
         kind = 2'($urandom);
         ofs  = 3'($urandom);
         data = 16'($urandom);
         send_beat(kind, ofs, data);
      end
   endtask

   // stop, load a setup (mostly small), start with random mode bits, then ticks and reads
   task automatic timer_run();
      logic [7:0]  hi;
      logic [7:0]  lo;
      logic [15:0] setup;
      logic [7:0]  run_mode;
      logic [2:0]  ofs;
      int          n;
      hi = 8'($urandom);
      lo = 8'($urandom);
      lo[MODE_START] = 1'b0;
      send_beat(REQ_WORD_WRITE, OFS_MODE, {hi, lo});
      if ($urandom_range(9) < 8) setup = 16'($urandom_range(0, 3));
      else setup = 16'($urandom);
      if ($urandom_range(1) == 0) begin
         send_beat(REQ_WORD_WRITE, OFS_SETUP_LO, setup);
      end else begin
         hi = 8'($urandom);
         send_beat(REQ_BYTE_WRITE, OFS_SETUP_LO, {hi, setup[7:0]});
         hi = 8'($urandom);
         send_beat(REQ_BYTE_WRITE, OFS_SETUP_HI, {hi, setup[15:8]});
      end
      run_mode = 8'($urandom);
      run_mode[MODE_START]  = 1'b1;
      run_mode[MODE_DIV16]  = ($urandom_range(7) == 0);
      run_mode[MODE_DIV4]   = ($urandom_range(3) == 0);
      run_mode[MODE_ENBEND] = ($urandom_range(3) != 0);
      hi = 8'($urandom);
      send_beat($urandom_range(1) ? REQ_WORD_WRITE : REQ_BYTE_WRITE, OFS_MODE, {hi, run_mode});
      n = $urandom_range(40, 400);
      for (int i = 0; i < n && beats_sent < PLANNED_BEATS; i++) begin
         if (i == n / 2 && $urandom_range(2) == 0) begin
            run_mode = 8'($urandom);
            run_mode[MODE_START] = 1'b1;
            hi = 8'($urandom);
            send_beat(REQ_WORD_WRITE, OFS_MODE, {hi, run_mode});
         end else if ($urandom_range(9) == 0) begin
            ofs = 3'($urandom);
            send_beat(REQ_WORD_READ, ofs, 16'($urandom));
         end else begin
            send_beat(REQ_TICK, 3'($urandom), 16'($urandom));
         end
      end
      send_beat(REQ_WORD_READ, OFS_COUNTER, 16'd0);
      send_beat(REQ_WORD_READ, OFS_MODE, 16'd0);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_beat(REQ_WORD_READ,  OFS_SETUP_LO, 16'h0000);
      send_beat(REQ_WORD_READ,  OFS_COUNTER,  16'hFFFF);
      send_beat(REQ_WORD_READ,  OFS_MODE,     16'h0000);
      send_beat(REQ_TICK,       3'd7,         16'hFFFF);
      send_beat(REQ_WORD_WRITE, OFS_SETUP_LO, 16'hFFFF);
      send_beat(REQ_BYTE_WRITE, OFS_SETUP_LO, 16'h1200);
      send_beat(REQ_BYTE_WRITE, OFS_SETUP_HI, 16'hFF34);
      send_beat(REQ_WORD_READ,  OFS_SETUP_LO, 16'h0000);
      // counter writes, odd and unused offsets: all ignored
      send_beat(REQ_WORD_WRITE, OFS_COUNTER,  16'hFFFF);
      send_beat(REQ_BYTE_WRITE, OFS_COUNTER,  16'h00FF);
      send_beat(REQ_BYTE_WRITE, 3'd3,         16'hFFFF);
      send_beat(REQ_BYTE_WRITE, 3'd5,         16'hFFFF);
      send_beat(REQ_BYTE_WRITE, 3'd6,         16'hFFFF);
      send_beat(REQ_BYTE_WRITE, 3'd7,         16'hFFFF);
      send_beat(REQ_WORD_WRITE, OFS_SETUP_HI, 16'hABCD);
      send_beat(REQ_WORD_WRITE, 3'd7,         16'h5555);
      send_beat(REQ_WORD_READ,  OFS_SETUP_HI, 16'h0000);
      send_beat(REQ_WORD_READ,  3'd3,         16'h0000);
      send_beat(REQ_WORD_READ,  3'd6,         16'h0000);
      send_beat(REQ_WORD_WRITE, OFS_SETUP_LO, 16'h0000);
      // once with continuous, start edge loads zero, high byte of data dropped
      send_beat(REQ_WORD_WRITE, OFS_MODE,     16'hAB9E);
      send_beat(REQ_WORD_READ,  OFS_COUNTER,  16'h0000);
      send_beat(REQ_WORD_READ,  OFS_MODE,     16'h0000);
      send_beat(REQ_WORD_WRITE, OFS_MODE,     16'hFF00);
      send_beat(REQ_WORD_READ,  OFS_MODE,     16'h0000);
      wait_replies();

      while (beats_sent < PLANNED_BEATS) begin
         if ($urandom_range(4) == 0) noise_burst();
         else timer_run();
         if ($urandom_range(5) == 0) wait_replies();
      end

      wait_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
